### rtl/core/v2a_pkg.sv
// Package for the two-component Q16.16 vector ALU.
// Holds operation and status codes, the pipeline item type and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
package v2a_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_DOT  = 3'd2;
  localparam logic [2:0] OP_SCL  = 3'd3;
  localparam logic [2:0] OP_LEN  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] sc;
    logic [1:0]         status;
  } item_t;

  // {clamped, value}
  function automatic logic [32:0] sat49(input logic signed [48:0] v);
    if (v > 49'sh0_7FFF_FFFF) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -49'sh0_8000_0000) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

endpackage

### rtl/core/v2a_mul.sv
// Front end: products in the first stage, add/sub/dot/scale results and sum of squares
// in the second. Depends on v2a_pkg.
`timescale 1ns / 1ps
module v2a_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] factor_i,
  output logic               valid_o,
  output v2a_pkg::item_t     item_o,
  output logic [63:0]        sq_o
);

  logic               v1_q;
  logic [2:0]         op1_q;
  logic signed [31:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic signed [63:0] pxb_q, pyb_q, pxf_q, pyf_q;
  logic [62:0]        sqx_q, sqy_q;
  logic signed [63:0] pxb_d, pyb_d, pxf_d, pyf_d, sqx_d, sqy_d;

  logic               v2_q;
  v2a_pkg::item_t     item_q, item_d;
  logic [63:0]        sq_q, sq_d;

  logic signed [48:0] add_x, add_y, sub_x, sub_y, dot_v, scl_x, scl_y;
  logic signed [64:0] dsum;
  logic [32:0]        sx, sy, sd;

  always_comb begin
    pxb_d = ax_i * bx_i;
    pyb_d = ay_i * by_i;
    pxf_d = ax_i * factor_i;
    pyf_d = ay_i * factor_i;
    sqx_d = ax_i * ax_i;
    sqy_d = ay_i * ay_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q  <= op_i;
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      bx1_q  <= bx_i;
      by1_q  <= by_i;
      pxb_q  <= pxb_d;
      pyb_q  <= pyb_d;
      pxf_q  <= pxf_d;
      pyf_q  <= pyf_d;
      sqx_q  <= sqx_d[62:0];
      sqy_q  <= sqy_d[62:0];
      item_q <= item_d;
      sq_q   <= sq_d;
    end
  end

  always_comb begin
    add_x = 49'(ax1_q) + 49'(bx1_q);
    add_y = 49'(ay1_q) + 49'(by1_q);
    sub_x = 49'(ax1_q) - 49'(bx1_q);
    sub_y = 49'(ay1_q) - 49'(by1_q);
    dsum  = 65'(pxb_q) + 65'(pyb_q);
    dot_v = $signed(dsum[64:16]);
    scl_x = 49'($signed(pxf_q[63:16]));
    scl_y = 49'($signed(pyf_q[63:16]));
    sq_d  = 64'(sqx_q) + 64'(sqy_q);

    item_d        = '0;
    item_d.op     = op1_q;
    item_d.ax     = ax1_q;
    item_d.ay     = ay1_q;
    item_d.status = v2a_pkg::ST_OK;
    sx = '0;
    sy = '0;
    sd = '0;
    unique case (op1_q)
      v2a_pkg::OP_ADD: begin
        sx = v2a_pkg::sat49(add_x);
        sy = v2a_pkg::sat49(add_y);
      end
      v2a_pkg::OP_SUB: begin
        sx = v2a_pkg::sat49(sub_x);
        sy = v2a_pkg::sat49(sub_y);
      end
      v2a_pkg::OP_DOT: begin
        sd = v2a_pkg::sat49(dot_v);
      end
      v2a_pkg::OP_SCL: begin
        sx = v2a_pkg::sat49(scl_x);
        sy = v2a_pkg::sat49(scl_y);
      end
      default: begin
      end
    endcase
    item_d.rx = sx[31:0];
    item_d.ry = sy[31:0];
    item_d.sc = sd[31:0];
    if (sx[32] || sy[32] || sd[32]) begin
      item_d.status = v2a_pkg::ST_SAT;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item_q;
  assign sq_o    = sq_q;

endmodule

### rtl/core/v2a_sqrt.sv
// Integer square root of the 64-bit sum of squares, one root bit per stage.
// Finishes the length operation at its output. Depends on v2a_pkg.
`timescale 1ns / 1ps
module v2a_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  v2a_pkg::item_t item_i,
  input  logic [63:0]    sq_i,
  output logic           valid_o,
  output v2a_pkg::item_t item_o,
  output logic [31:0]    len_o
);

  localparam int unsigned N = v2a_pkg::SQRT_STEPS;

  logic           v_q    [N];
  v2a_pkg::item_t item_q [N];
  logic [34:0]    rem_q  [N];
  logic [31:0]    root_q [N];
  logic [63:0]    src_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           v_in;
    v2a_pkg::item_t item_in;
    logic [34:0]    rem_in, rem_t, trial;
    logic [31:0]    root_in;
    logic [63:0]    src_in;
    logic           ge;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign item_in = item_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = sq_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign item_in = item_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign src_in  = src_q[g-1];
    end

    always_comb begin
      rem_t = {rem_in[32:0], src_in[63:62]};
      trial = {1'b0, root_in, 2'b01};
      ge    = (rem_t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (adv_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        item_q[g] <= item_in;
        rem_q[g]  <= ge ? (rem_t - trial) : rem_t;
        root_q[g] <= {root_in[30:0], ge};
        src_q[g]  <= {src_in[61:0], 2'b00};
      end
    end
  end

  always_comb begin
    item_o = item_q[N-1];
    len_o  = root_q[N-1];
    if (item_q[N-1].op == v2a_pkg::OP_LEN) begin
      if (len_o[31]) begin
        item_o.sc     = 32'h7FFF_FFFF;
        item_o.status = v2a_pkg::ST_SAT;
      end else begin
        item_o.sc = len_o;
      end
    end
  end

  assign valid_o = v_q[N-1];

endmodule

### rtl/core/v2a_div.sv
// Two-lane restoring divider for normalize, one quotient bit per stage.
// Finishes the normalize operation at its output. Depends on v2a_pkg.
`timescale 1ns / 1ps
module v2a_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  v2a_pkg::item_t item_i,
  input  logic [31:0]    len_i,
  output logic           valid_o,
  output v2a_pkg::item_t item_o
);

  localparam int unsigned N = v2a_pkg::DIV_STEPS;

  logic           v_q    [N];
  v2a_pkg::item_t item_q [N];
  logic [31:0]    len_q  [N];
  logic [32:0]    rx_q   [N];
  logic [32:0]    ry_q   [N];
  logic [N-1:0]   qx_q   [N];
  logic [N-1:0]   qy_q   [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic           v_in;
    v2a_pkg::item_t item_in;
    logic [31:0]    len_in;
    logic [32:0]    rx_in, ry_in;
    logic [N-1:0]   qx_in, qy_in;
    logic           gex, gey;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign item_in = item_i;
      assign len_in  = len_i;
      assign rx_in   = {1'b0, item_i.ax[31] ? (~item_i.ax + 32'd1) : item_i.ax};
      assign ry_in   = {1'b0, item_i.ay[31] ? (~item_i.ay + 32'd1) : item_i.ay};
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign item_in = item_q[g-1];
      assign len_in  = len_q[g-1];
      assign rx_in   = {rx_q[g-1][31:0], 1'b0};
      assign ry_in   = {ry_q[g-1][31:0], 1'b0};
      assign qx_in   = qx_q[g-1];
      assign qy_in   = qy_q[g-1];
    end

    always_comb begin
      gex = (rx_in >= {1'b0, len_in});
      gey = (ry_in >= {1'b0, len_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (adv_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        item_q[g] <= item_in;
        len_q[g]  <= len_in;
        rx_q[g]   <= gex ? (rx_in - {1'b0, len_in}) : rx_in;
        ry_q[g]   <= gey ? (ry_in - {1'b0, len_in}) : ry_in;
        qx_q[g]   <= {qx_in[N-2:0], gex};
        qy_q[g]   <= {qy_in[N-2:0], gey};
      end
    end
  end

  logic [31:0] qx, qy;

  always_comb begin
    qx     = 32'(qx_q[N-1]);
    qy     = 32'(qy_q[N-1]);
    item_o = item_q[N-1];
    if (item_q[N-1].op == v2a_pkg::OP_NORM) begin
      if (len_q[N-1] == '0) begin
        item_o.rx     = '0;
        item_o.ry     = '0;
        item_o.status = v2a_pkg::ST_ZERO;
      end else begin
        item_o.rx = item_q[N-1].ax[31] ? (~qx + 32'd1) : qx;
        item_o.ry = item_q[N-1].ay[31] ? (~qy + 32'd1) : qy;
      end
    end
  end

  assign valid_o = v_q[N-1];

endmodule

### rtl/core/vec2_fixed_point_alu.sv
// Top level of the two-component Q16.16 vector ALU: front end, square root, divider
// and output register. Depends on v2a_pkg, v2a_mul, v2a_sqrt, v2a_div.
//
//   channel | signals                                          | dir
//   in      | in_valid_i, in_stall_o, operation_i, ax_i, ay_i,  | in
//           | bx_i, by_i, factor_i                             |
//   out     | out_valid_o, out_stall_i, rx_o, ry_o,            | out
//           | scalar_out_o, status_o                           |
//
// Every operation passes through 2 front-end stages, 32 square-root stages
// (one root bit each), 17 divider stages (one quotient bit each) and the output register.
// One item enters per cycle while the output is not stalled.
// A stall on a valid output freezes the whole pipeline; reset clears only the valid bits.
`timescale 1ns / 1ps
module vec2_fixed_point_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] factor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rx_o,
  output logic signed [31:0] ry_o,
  output logic signed [31:0] scalar_out_o,
  output logic [1:0]         status_o
);

  logic           adv;
  logic           mul_v, sqrt_v, div_v;
  v2a_pkg::item_t mul_item, sqrt_item, div_item;
  logic [63:0]    sq;
  logic [31:0]    len;

  logic           out_valid_q;
  logic [31:0]    rx_q, ry_q, sc_q;
  logic [1:0]     status_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  v2a_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .op_i     (operation_i),
    .ax_i     (ax_i),
    .ay_i     (ay_i),
    .bx_i     (bx_i),
    .by_i     (by_i),
    .factor_i (factor_i),
    .valid_o  (mul_v),
    .item_o   (mul_item),
    .sq_o     (sq)
  );

  v2a_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (mul_v),
    .item_i  (mul_item),
    .sq_i    (sq),
    .valid_o (sqrt_v),
    .item_o  (sqrt_item),
    .len_o   (len)
  );

  v2a_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sqrt_v),
    .item_i  (sqrt_item),
    .len_i   (len),
    .valid_o (div_v),
    .item_o  (div_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q     <= div_item.rx;
      ry_q     <= div_item.ry;
      sc_q     <= div_item.sc;
      status_q <= div_item.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rx_o         = rx_q;
  assign ry_o         = ry_q;
  assign scalar_out_o = sc_q;
  assign status_o     = status_q;

  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == v2a_pkg::ST_ZERO |-> rx_o == '0 && ry_o == '0
      && scalar_out_o == '0)
    else $error("zero-length normalize gave a nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_scalar_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scalar_out_o != '0 |-> rx_o == '0 && ry_o == '0)
    else $error("scalar and vector results both nonzero");

endmodule
